// ----- rtl/core/order_message_stream_counter_core_assert.svh -----
// assertion macros shared by the core rtl
`ifndef ORDER_MESSAGE_STREAM_COUNTER_CORE_ASSERT_SVH
`define ORDER_MESSAGE_STREAM_COUNTER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define OMSC_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define OMSC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define OMSC_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define OMSC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- rtl/core/omsc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// omsc_pkg
// Shared types, codes and helpers of the order message stream counter.
// ----------------------------------------------------------------------------
package omsc_pkg;

    typedef logic [32:0] pos_t;

    typedef enum logic [2:0] {
        EV_COUNTED      = 3'd0,
        EV_FRAGMENT     = 3'd1,
        EV_CONTINUATION = 3'd2,
        EV_LENGTH_ABORT = 3'd3,
        EV_STREAM_RANGE = 3'd4,
        EV_READ_DATA    = 3'd5
    } event_kind_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

    typedef struct packed {
        logic       hit;
        logic [2:0] code;
    } type_hit_t;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [2:0] TYPE_ACCEPTED = 3'd0;
    localparam logic [2:0] TYPE_SYSTEM   = 3'd1;
    localparam logic [2:0] TYPE_REPLACED = 3'd2;
    localparam logic [2:0] TYPE_CANCEL   = 3'd3;
    localparam logic [2:0] TYPE_EXECUTED = 3'd4;
    localparam logic [2:0] ITEM_SHARE    = 3'd5;
    localparam int         NUM_TYPES     = 5;

    localparam logic [7:0] CHAR_A = 8'h41;
    localparam logic [7:0] CHAR_S = 8'h53;
    localparam logic [7:0] CHAR_U = 8'h55;
    localparam logic [7:0] CHAR_C = 8'h43;
    localparam logic [7:0] CHAR_E = 8'h45;

    localparam pos_t POS_STREAM_HI   = 33'd0;
    localparam pos_t POS_STREAM_LO   = 33'd1;
    localparam pos_t POS_PLEN_LAST   = 33'd5;
    localparam pos_t POS_MLEN_HI     = 33'd6;
    localparam pos_t POS_TYPE        = 33'd9;
    localparam pos_t POS_SHARE_FIRST = 33'd32;
    localparam pos_t POS_SHARE_LAST  = 33'd35;
    localparam pos_t FRAG_EXTRA      = 33'd6;
    localparam pos_t FRAG_MIN        = 33'd8;
    localparam pos_t SPAN_EXTRA      = 33'd8;
    localparam pos_t MSG_MIN         = 33'd10;
    localparam pos_t LEN_PAD         = 33'd2;

    function automatic logic length_is_normal(input logic [15:0] len);
        return (len == 16'd11) || (len == 16'd29) || (len == 16'd41) ||
               (len == 16'd66) || (len == 16'd80);
    endfunction

    function automatic type_hit_t type_lookup(input logic [7:0] b);
        type_hit_t r;
        r.hit  = 1'b1;
        r.code = TYPE_ACCEPTED;
        case (b)
            CHAR_A: r.code = TYPE_ACCEPTED;
            CHAR_S: r.code = TYPE_SYSTEM;
            CHAR_U: r.code = TYPE_REPLACED;
            CHAR_C: r.code = TYPE_CANCEL;
            CHAR_E: r.code = TYPE_EXECUTED;
            default: r.hit = 1'b0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/order_message_stream_counter_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// order_message_stream_counter_core
// Byte-serial packet parser with per-stream message counters and share
// totals held in one row memory.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  s_       in   s_valid/s_ready    op, data_byte, read_stream, read_item
//  m_       out  m_valid/m_ready    event_kind, stream_id, type_code, value
//  cfg_     in   cfg_wr_en          check_length
//
// one beat per cycle while s_ready is high; the row memory reads the row at the
// accept edge, the update stage uses it, and the result goes to the output register
// after reset a sweep clears every row of the row memory, with s_ready low meanwhile
// a held result stalls the update stage, which then stalls s_ready
`include "order_message_stream_counter_core_assert.svh"
module order_message_stream_counter_core #(
    parameter int STREAM_SLOTS = 16,
    parameter int COUNTER_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [7:0]  s_data_byte,
    input  logic [3:0]  s_read_stream,
    input  logic [2:0]  s_read_item,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_event_kind,
    output logic [15:0] m_stream_id,
    output logic [2:0]  m_type_code,
    output logic [31:0] m_value
);
    import omsc_pkg::*;

    localparam int SW         = (STREAM_SLOTS > 1) ? $clog2(STREAM_SLOTS) : 1;
    localparam int SHARE_LSB  = NUM_TYPES * COUNTER_BITS;
    localparam int RESUME_LSB = SHARE_LSB + 32;
    localparam int ROW_W      = RESUME_LSB + 32;

    typedef enum logic [1:0] {
        MODE_HEADER,
        MODE_TYPE,
        MODE_SHARE,
        MODE_SKIP
    } mode_t;

    // parser state
    mode_t       mode_reg, mode_next;
    pos_t        pos_reg, pos_next;
    pos_t        end_reg, end_next;
    logic [15:0] stream_reg, stream_next;
    logic [31:0] plen_reg, plen_next;
    logic [15:0] mlen_reg, mlen_next;
    logic [31:0] shift_reg, shift_next;
    logic        aborted_reg, aborted_next;
    logic        check_reg;

    // update stage
    logic        b_valid_reg;
    logic        b_op_reg;
    logic [7:0]  b_byte_reg;
    logic [3:0]  b_slot_reg;
    logic [2:0]  b_item_reg;
    logic        b_go;

    // output register
    logic        m_valid_reg;
    event_kind_t m_kind_reg;
    logic [15:0] m_stream_reg;
    logic [2:0]  m_type_reg;
    logic [31:0] m_value_reg;

    logic        emit;
    event_kind_t ev_kind;
    logic [15:0] ev_stream;
    logic [2:0]  ev_type;
    logic [31:0] ev_value;

    mem_ctl_t    mem_ctl;
    logic        clr_busy;
    logic        accept;
    logic [SW-1:0]    rd_addr;
    logic [15:0]      rd_stream;
    logic [ROW_W-1:0] row_in;
    logic [ROW_W-1:0] wr_row;
    logic             wr_en;

    assign b_go    = b_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !clr_busy && (!b_valid_reg || b_go);
    assign accept  = s_valid && s_ready;

    // row to fetch for the beat entering now, from the state after the beat in update
    always_comb begin
        if (s_op == OP_READ) begin
            rd_stream = 16'(s_read_stream);
        end else if (mode_next == MODE_HEADER && pos_next == POS_STREAM_LO) begin
            rd_stream = {stream_next[15:8], s_data_byte};
        end else begin
            rd_stream = stream_next;
        end
    end
    assign rd_addr = rd_stream[SW-1:0];

    assign mem_ctl.rd_en = accept;
    assign mem_ctl.wr_en = wr_en;

    omsc_row_mem #(
        .DEPTH (STREAM_SLOTS),
        .AW    (SW),
        .W     (ROW_W)
    ) u_row_mem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (mem_ctl),
        .rd_addr  (rd_addr),
        .wr_addr  (stream_next[SW-1:0]),
        .wr_row   (wr_row),
        .rd_row   (row_in),
        .clr_busy (clr_busy)
    );

    always_comb begin
        logic [15:0]          full_stream;
        logic [15:0]          mlen_full;
        pos_t                 mlen33;
        pos_t                 plen33;
        pos_t                 span_frag;
        pos_t                 span_msg;
        pos_t                 pos_inc;
        logic                 frag;
        logic                 hold_pos;
        logic [31:0]          resume_in;
        logic [31:0]          share_in;
        logic [31:0]          sh;
        logic [COUNTER_BITS-1:0] cnt;
        type_hit_t            th;

        mode_next    = mode_reg;
        pos_next     = pos_reg;
        end_next     = end_reg;
        stream_next  = stream_reg;
        plen_next    = plen_reg;
        mlen_next    = mlen_reg;
        shift_next   = shift_reg;
        aborted_next = aborted_reg;
        emit         = 1'b0;
        ev_kind      = EV_COUNTED;
        ev_stream    = stream_reg;
        ev_type      = TYPE_ACCEPTED;
        ev_value     = '0;
        wr_en        = 1'b0;
        wr_row       = row_in;
        hold_pos     = 1'b0;
        resume_in    = row_in[RESUME_LSB +: 32];
        share_in     = row_in[SHARE_LSB +: 32];
        full_stream  = {stream_reg[15:8], b_byte_reg};
        mlen_full    = {mlen_reg[15:8], b_byte_reg};
        mlen33       = 33'(mlen_full);
        plen33       = 33'(plen_reg);
        frag         = plen33 < (mlen33 + LEN_PAD);
        span_frag    = plen33 + FRAG_EXTRA;
        if (span_frag < FRAG_MIN) begin
            span_frag = FRAG_MIN;
        end
        span_msg     = mlen33 + SPAN_EXTRA;
        sh           = {shift_reg[23:0], b_byte_reg};
        th           = type_lookup(b_byte_reg);
        cnt          = row_in[int'(th.code) * COUNTER_BITS +: COUNTER_BITS] + 1'b1;
        pos_inc      = pos_reg + 1'b1;

        if (b_go && b_op_reg == OP_READ) begin
            emit      = 1'b1;
            ev_kind   = EV_READ_DATA;
            ev_stream = 16'(b_slot_reg);
            if (32'(b_slot_reg) < 32'(STREAM_SLOTS)) begin
                case (b_item_reg)
                    TYPE_ACCEPTED: ev_value = 32'(row_in[0 +: COUNTER_BITS]);
                    TYPE_SYSTEM:   ev_value = 32'(row_in[COUNTER_BITS +: COUNTER_BITS]);
                    TYPE_REPLACED: ev_value = 32'(row_in[2*COUNTER_BITS +: COUNTER_BITS]);
                    TYPE_CANCEL:   ev_value = 32'(row_in[3*COUNTER_BITS +: COUNTER_BITS]);
                    TYPE_EXECUTED: ev_value = 32'(row_in[4*COUNTER_BITS +: COUNTER_BITS]);
                    ITEM_SHARE:    ev_value = share_in;
                    default:       ev_value = '0;
                endcase
            end
        end else if (b_go && !aborted_reg) begin
            case (mode_reg)
                MODE_HEADER: begin
                    if (pos_reg == POS_STREAM_HI) begin
                        stream_next = {b_byte_reg, 8'd0};
                    end else if (pos_reg == POS_STREAM_LO) begin
                        stream_next = full_stream;
                        if (32'(full_stream) < 32'(STREAM_SLOTS) && resume_in != '0) begin
                            // continuation of a fragment: skip the whole packet
                            end_next  = 33'(resume_in) + SPAN_EXTRA;
                            wr_en     = 1'b1;
                            wr_row[RESUME_LSB +: 32] = '0;
                            mode_next = MODE_SKIP;
                            emit      = 1'b1;
                            ev_kind   = EV_CONTINUATION;
                            ev_stream = full_stream;
                        end
                    end else if (pos_reg <= POS_PLEN_LAST) begin
                        plen_next = {plen_reg[23:0], b_byte_reg};
                    end else if (pos_reg == POS_MLEN_HI) begin
                        mlen_next = {b_byte_reg, 8'd0};
                    end else begin
                        mlen_next = mlen_full;
                        if (32'(stream_reg) >= 32'(STREAM_SLOTS)) begin
                            end_next  = frag ? span_frag : span_msg;
                            mode_next = MODE_SKIP;
                            emit      = 1'b1;
                            ev_kind   = EV_STREAM_RANGE;
                        end else if (check_reg && !length_is_normal(mlen_full)) begin
                            aborted_next = 1'b1;
                            hold_pos     = 1'b1;
                            emit         = 1'b1;
                            ev_kind      = EV_LENGTH_ABORT;
                            ev_value     = 32'(mlen_full);
                        end else if (frag) begin
                            wr_en     = 1'b1;
                            wr_row[RESUME_LSB +: 32] = 32'(mlen_full) - plen_reg;
                            end_next  = span_frag;
                            mode_next = MODE_SKIP;
                            emit      = 1'b1;
                            ev_kind   = EV_FRAGMENT;
                        end else begin
                            end_next  = (span_msg < MSG_MIN) ? MSG_MIN : span_msg;
                            mode_next = MODE_TYPE;
                        end
                    end
                end
                MODE_TYPE: begin
                    if (pos_reg == POS_TYPE) begin
                        mode_next = MODE_SKIP;
                        if (th.hit && 32'(stream_reg) < 32'(STREAM_SLOTS)) begin
                            wr_en = 1'b1;
                            wr_row[int'(th.code) * COUNTER_BITS +: COUNTER_BITS] = cnt;
                            emit     = 1'b1;
                            ev_kind  = EV_COUNTED;
                            ev_type  = th.code;
                            ev_value = 32'(cnt);
                            if (th.code == TYPE_EXECUTED && end_reg > POS_SHARE_LAST) begin
                                shift_next = '0;
                                mode_next  = MODE_SHARE;
                            end
                        end
                    end
                end
                MODE_SHARE: begin
                    if (pos_reg >= POS_SHARE_FIRST && pos_reg <= POS_SHARE_LAST) begin
                        shift_next = sh;
                        if (pos_reg == POS_SHARE_LAST) begin
                            wr_en     = 1'b1;
                            wr_row[SHARE_LSB +: 32] = share_in + sh;
                            mode_next = MODE_SKIP;
                        end
                    end
                end
                default: ;
            endcase

            if (!hold_pos) begin
                if (mode_next != MODE_HEADER && pos_inc >= end_next) begin
                    pos_next  = '0;
                    mode_next = MODE_HEADER;
                    plen_next = '0;
                end else begin
                    pos_next = pos_inc;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_HEADER;
            pos_reg      <= '0;
            end_reg      <= '0;
            stream_reg   <= '0;
            plen_reg     <= '0;
            mlen_reg     <= '0;
            shift_reg    <= '0;
            aborted_reg  <= 1'b0;
            check_reg    <= 1'b0;
            b_valid_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            mode_reg     <= mode_next;
            pos_reg      <= pos_next;
            end_reg      <= end_next;
            stream_reg   <= stream_next;
            plen_reg     <= plen_next;
            mlen_reg     <= mlen_next;
            shift_reg    <= shift_next;
            aborted_reg  <= aborted_next;
            if (cfg_wr_en) begin
                check_reg <= cfg_wr_data;
            end
            if (accept) begin
                b_valid_reg <= 1'b1;
            end else if (b_go) begin
                b_valid_reg <= 1'b0;
            end
            if (b_go && emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            b_op_reg   <= s_op;
            b_byte_reg <= s_data_byte;
            b_slot_reg <= s_read_stream;
            b_item_reg <= s_read_item;
        end
        if (b_go && emit) begin
            m_kind_reg   <= ev_kind;
            m_stream_reg <= ev_stream;
            m_type_reg   <= ev_type;
            m_value_reg  <= ev_value;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_event_kind = m_kind_reg;
    assign m_stream_id  = m_stream_reg;
    assign m_type_code  = m_type_reg;
    assign m_value      = m_value_reg;

    `OMSC_ASSERT_IMPLY(a_no_accept_in_clear, aclk, aresetn, clr_busy, !s_ready)
    `OMSC_ASSERT_NEXT(a_abort_sticky, aclk, aresetn, aborted_reg, aborted_reg)
    `OMSC_ASSERT_IMPLY(a_write_only_on_update, aclk, aresetn, mem_ctl.wr_en, b_go && !clr_busy)
    `OMSC_ASSERT_NEXT(a_update_stall_holds, aclk, aresetn, b_valid_reg && !b_go, b_valid_reg)

endmodule
`default_nettype wire

// ----- rtl/core/omsc_row_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// omsc_row_mem
// Per-stream row memory with registered read, write forwarding and a
// clearing sweep after reset.
// ----------------------------------------------------------------------------
module omsc_row_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int W     = 224
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  omsc_pkg::mem_ctl_t ctl,
    input  logic [AW-1:0]     rd_addr,
    input  logic [AW-1:0]     wr_addr,
    input  logic [W-1:0]      wr_row,
    output logic [W-1:0]      rd_row,
    output logic              clr_busy
);
    import omsc_pkg::*;

    logic [W-1:0]  row_mem [DEPTH];
    logic [W-1:0]  dout_reg;
    logic [W-1:0]  fwd_row_reg;
    logic          fwd_hit_reg;
    logic          clr_busy_reg;
    logic [AW-1:0] clr_idx_reg;

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            row_mem[clr_idx_reg] <= '0;
        end else if (ctl.wr_en) begin
            row_mem[wr_addr] <= wr_row;
        end
        if (ctl.rd_en) begin
            dout_reg <= row_mem[rd_addr];
        end
        if (ctl.wr_en) begin
            fwd_row_reg <= wr_row;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
            fwd_hit_reg  <= 1'b0;
        end else begin
            if (clr_busy_reg) begin
                if (clr_idx_reg == AW'(DEPTH - 1)) begin
                    clr_busy_reg <= 1'b0;
                end else begin
                    clr_idx_reg <= clr_idx_reg + 1'b1;
                end
            end
            // read and write of one row in the same cycle: take the new row
            if (ctl.rd_en) begin
                fwd_hit_reg <= ctl.wr_en && (wr_addr == rd_addr);
            end
        end
    end

    assign rd_row   = fwd_hit_reg ? fwd_row_reg : dout_reg;
    assign clr_busy = clr_busy_reg;

endmodule
`default_nettype wire
